// ===== rtl/lsc_pkg.sv =====
// shared types and constants for the lru slot cache
package lsc_pkg;

    // default sizing
    localparam int MAX_SLOTS_DEF = 64;
    localparam int KEY_BITS_DEF  = 48;

    // field widths
    localparam int BLOCK_KEY_W = 48;
    localparam int SLOT_ID_W   = 6;
    localparam int CFG_W       = 7;

    // stream bus widths
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 56;
    localparam int M_TUSER_W = 2;

    // tuser bit positions on the result side
    localparam int TUSER_HIT     = 0;
    localparam int TUSER_EVICTED = 1;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } t_lsc_state;

    // controls broadcast to every cell
    typedef struct packed {
        logic upd;
        logic clr;
    } t_lsc_cell_ctl;

    // status each cell reports back
    typedef struct packed {
        logic match;
        logic first_free;
        logic last;
    } t_lsc_cell_flags;

endpackage

// ===== rtl/lru_slot_cache.sv =====
// fully associative lru cache mapping block keys to memory slots
//
//  channel   | direction | handshake                      | contents
//  ----------+-----------+--------------------------------+------------------------------------
//  s_axis    | in        | s_axis_tvalid / s_axis_tready  | tdata: block_key
//  m_axis    | out       | m_axis_tvalid / m_axis_tready  | tdata: slot_id, evicted_key
//            |           |                                | tuser: hit, evicted
//  cfg       | in        | i_cfg_we (no wait)             | i_cfg_wdata: slots_in_use
//
//  an item passes a compare state, which checks the key against every cell of the
//  recency chain, then an update state, which shifts the chain and loads the result register.
//  a new item is taken in the same cycle the previous one updates the chain.
//  a cfg write clears all cells at once; there is no clearing pass.
//  a full result register that is not taken holds the update stage.
//  reset: synchronous, active low; slots_in_use comes up as min(MAX_SLOTS, 64).
module lru_slot_cache #(
    parameter int MAX_SLOTS = lsc_pkg::MAX_SLOTS_DEF,
    parameter int KEY_BITS  = lsc_pkg::KEY_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [lsc_pkg::CFG_W-1:0]     i_cfg_wdata,
    // request stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [lsc_pkg::S_TDATA_W-1:0] s_axis_tdata,   // [47:0] block_key
    // result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [lsc_pkg::M_TDATA_W-1:0] m_axis_tdata,   // [5:0] slot_id, [53:6] evicted_key
    output logic [lsc_pkg::M_TUSER_W-1:0] m_axis_tuser    // [0] hit, [1] evicted
);

    localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
    localparam int CMP_W  = (KEY_BITS < lsc_pkg::BLOCK_KEY_W) ? KEY_BITS : lsc_pkg::BLOCK_KEY_W;
    localparam int RST_N  = (MAX_SLOTS < 64) ? MAX_SLOTS : 64;

    lsc_pkg::t_lsc_state r_state;
    lsc_pkg::t_lsc_state n_state;

    logic [CMP_W-1:0]     r_key;
    logic [MAX_SLOTS-1:0] r_take;
    logic                 r_hit;
    logic                 r_evict;
    logic [CNT_W-1:0]     r_free;

    logic                          r_out_valid;
    logic [lsc_pkg::SLOT_ID_W-1:0] r_out_slot;
    logic                          r_out_hit;
    logic                          r_out_evict;
    logic [lsc_pkg::BLOCK_KEY_W-1:0] r_out_ekey;

    logic in_acc;
    logic upd_done;
    logic any_hit;
    logic no_free;

    logic [CNT_W-1:0] cfg_n;

    lsc_pkg::t_lsc_cell_ctl   cell_ctl;
    lsc_pkg::t_lsc_cell_flags flags [MAX_SLOTS];
    logic [CMP_W-1:0]         cell_key   [MAX_SLOTS];
    logic [SLOT_W-1:0]        cell_slot  [MAX_SLOTS];
    logic [MAX_SLOTS-1:0]     cell_valid;

    logic [MAX_SLOTS-1:0] match_vec;
    logic [MAX_SLOTS-1:0] free_vec;
    logic [MAX_SLOTS-1:0] last_vec;
    logic [MAX_SLOTS-1:0] n_take;

    logic [SLOT_W-1:0]        sel_slot;
    logic [CMP_W-1:0]         sel_key;
    logic [SLOT_W-1:0]        pos;
    logic [SLOT_W-1:0]        front_slot;
    logic [SLOT_W+lsc_pkg::SLOT_ID_W-1:0] slot_ext;

    // handshakes
    assign upd_done      = (r_state == lsc_pkg::ST_UPD) && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = (r_state == lsc_pkg::ST_IDLE) || upd_done;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lsc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lsc_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_state = lsc_pkg::ST_CMP;
                end
            end
            lsc_pkg::ST_CMP: begin
                n_state = lsc_pkg::ST_UPD;
            end
            lsc_pkg::ST_UPD: begin
                if (upd_done) begin
                    n_state = in_acc ? lsc_pkg::ST_CMP : lsc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lsc_pkg::ST_IDLE;
            end
        endcase
    end

    // the recency chain: cell 0 is the most recent entry
    assign cell_ctl.upd = upd_done;
    assign cell_ctl.clr = i_cfg_we;

    for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_cell
        logic [CMP_W-1:0]  prev_key;
        logic [SLOT_W-1:0] prev_slot;
        logic              prev_valid;
        logic              next_valid;

        if (g == 0) begin : g_head
            assign prev_key   = r_key;
            assign prev_slot  = front_slot;
            assign prev_valid = 1'b1;
        end else begin : g_body
            assign prev_key   = cell_key[g-1];
            assign prev_slot  = cell_slot[g-1];
            assign prev_valid = cell_valid[g-1];
        end

        if (g == MAX_SLOTS - 1) begin : g_tail
            assign next_valid = 1'b0;
        end else begin : g_mid
            assign next_valid = cell_valid[g+1];
        end

        lsc_cell #(
            .IDX    (g),
            .SLOT_W (SLOT_W),
            .CMP_W  (CMP_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (cell_ctl),
            .i_pos        (pos),
            .i_lookup_key (r_key),
            .i_prev_key   (prev_key),
            .i_prev_slot  (prev_slot),
            .i_prev_valid (prev_valid),
            .i_next_valid (next_valid),
            .o_key        (cell_key[g]),
            .o_slot       (cell_slot[g]),
            .o_valid      (cell_valid[g]),
            .o_flags      (flags[g])
        );

        assign match_vec[g] = flags[g].match;
        assign free_vec[g]  = flags[g].first_free;
        assign last_vec[g]  = flags[g].last;
    end

    // compare stage: pick the position that leaves or joins the chain
    assign any_hit = |match_vec;
    assign no_free = (r_free == '0);

    always_comb begin
        if (any_hit) begin
            n_take = match_vec;
        end else if (!no_free) begin
            n_take = free_vec;
        end else begin
            n_take = last_vec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_key <= s_axis_tdata[CMP_W-1:0];
        end
        if (r_state == lsc_pkg::ST_CMP) begin
            r_take  <= n_take;
            r_hit   <= any_hit;
            r_evict <= !any_hit && no_free;
        end
    end

    // update stage: one-hot select of the taken cell and its position
    always_comb begin
        sel_slot = '0;
        sel_key  = '0;
        pos      = '0;
        for (int i = 0; i < MAX_SLOTS; i++) begin
            if (r_take[i]) begin
                sel_slot = sel_slot | cell_slot[i];
                sel_key  = sel_key | cell_key[i];
                pos      = pos | SLOT_W'(i);
            end
        end
    end

    assign front_slot = (r_hit || r_evict) ? sel_slot : SLOT_W'(r_free - CNT_W'(1));
    assign slot_ext   = (SLOT_W + lsc_pkg::SLOT_ID_W)'(front_slot);

    // clamp the written slot count into 1..MAX_SLOTS
    always_comb begin
        if (i_cfg_wdata == '0) begin
            cfg_n = CNT_W'(1);
        end else if (32'(i_cfg_wdata) > MAX_SLOTS) begin
            cfg_n = CNT_W'(MAX_SLOTS);
        end else begin
            cfg_n = CNT_W'(i_cfg_wdata);
        end
    end

    // free slot counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free <= CNT_W'(RST_N);
        end else if (i_cfg_we) begin
            r_free <= cfg_n;
        end else if (upd_done && !r_hit && !r_evict) begin
            r_free <= r_free - CNT_W'(1);
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (upd_done) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (upd_done) begin
            r_out_slot  <= slot_ext[lsc_pkg::SLOT_ID_W-1:0];
            r_out_hit   <= r_hit;
            r_out_evict <= r_evict;
            r_out_ekey  <= r_evict ? lsc_pkg::BLOCK_KEY_W'(sel_key) : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_ekey, r_out_slot};
    assign m_axis_tuser  = {r_out_evict, r_out_hit};

    // the taken position is a single cell
    a_take_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lsc_pkg::ST_UPD) |-> $onehot(r_take))
        else $error("update stage without a single taken cell");

    // a hit never evicts
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lsc_pkg::ST_UPD) |-> !(r_hit && r_evict))
        else $error("hit and eviction flagged together");

    // valid cells always form an unbroken run from the head of the chain
    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((cell_valid & (cell_valid + MAX_SLOTS'(1))) == '0))
        else $error("gap in the recency chain");

    // an eviction only happens once every slot is handed out
    a_evict_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lsc_pkg::ST_UPD && r_evict) |-> (r_free == '0))
        else $error("eviction while free slots remain");

    // an accepted item goes straight to the compare stage
    a_acc_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == lsc_pkg::ST_CMP))
        else $error("accepted item did not enter compare");

endmodule

// ===== rtl/lsc_cell.sv =====
// one recency cell: holds a key and its slot, shifts toward older positions
module lsc_cell #(
    parameter int IDX    = 0,
    parameter int SLOT_W = 6,
    parameter int CMP_W  = 48
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  lsc_pkg::t_lsc_cell_ctl i_ctl,
    input  logic [SLOT_W-1:0]      i_pos,
    input  logic [CMP_W-1:0]       i_lookup_key,
    input  logic [CMP_W-1:0]       i_prev_key,
    input  logic [SLOT_W-1:0]      i_prev_slot,
    input  logic                   i_prev_valid,
    input  logic                   i_next_valid,
    output logic [CMP_W-1:0]       o_key,
    output logic [SLOT_W-1:0]      o_slot,
    output logic                   o_valid,
    output lsc_pkg::t_lsc_cell_flags o_flags
);

    logic [CMP_W-1:0]  r_key;
    logic [SLOT_W-1:0] r_slot;
    logic              r_valid;
    logic              n_valid;
    logic              shift;

    // cells up to the taken position move one step older
    assign shift = i_ctl.upd && (SLOT_W'(IDX) <= i_pos);

    // valid bit next value
    always_comb begin
        n_valid = r_valid;
        if (i_ctl.clr) begin
            n_valid = 1'b0;
        end else if (shift) begin
            n_valid = i_prev_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // entry payload
    always_ff @(posedge i_clk) begin
        if (shift) begin
            r_key  <= i_prev_key;
            r_slot <= i_prev_slot;
        end
    end

    // lookup and position status
    assign o_flags.match      = r_valid && (r_key == i_lookup_key);
    assign o_flags.first_free = !r_valid && i_prev_valid;
    assign o_flags.last       = r_valid && !i_next_valid;

    assign o_key   = r_key;
    assign o_slot  = r_slot;
    assign o_valid = r_valid;

endmodule

// ===== bench/lru_slot_cache_test.sv =====
// testbench for lru_slot_cache: directed and random key streams checked against a slot map model
module lru_slot_cache_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SLOTS    = lsc_pkg::MAX_SLOTS_DEF;
    localparam int QUIET_CYCLES = 8;
    localparam int MAX_REPORTS  = 10;

    // what the driver does next
    typedef enum logic [1:0] {
        ORD_KEY,
        ORD_CFG,
        ORD_DRAIN,
        ORD_MODE
    } t_order_kind;

    typedef struct {
        t_order_kind                     kind;
        logic [lsc_pkg::BLOCK_KEY_W-1:0] key;
        logic [lsc_pkg::CFG_W-1:0]       cfg;
        int                              send_idle;
        int                              recv_idle;
    } t_order;

    // one slot grant as the block reports it
    typedef struct packed {
        logic [lsc_pkg::SLOT_ID_W-1:0]   slot_id;
        logic                            hit;
        logic                            evicted;
        logic [lsc_pkg::BLOCK_KEY_W-1:0] evicted_key;
    } t_grant;

    logic                            i_clk         = 1'b0;
    logic                            i_rst_n       = 1'b0;
    logic                            i_cfg_we      = 1'b0;
    logic [lsc_pkg::CFG_W-1:0]       i_cfg_wdata   = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [lsc_pkg::S_TDATA_W-1:0]   s_axis_tdata  = '0;   // [47:0] block_key
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [lsc_pkg::M_TDATA_W-1:0]   m_axis_tdata;   // [5:0] slot_id, [53:6] evicted_key
    logic [lsc_pkg::M_TUSER_W-1:0]   m_axis_tuser;   // [0] hit, [1] evicted

    t_order order_q [$];
    t_grant slot_grants [$];
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    int     quiet_count   = 0;
    int     fail_count    = 0;
    bit     key_taken     = 1'b0;

    // slot map model state
    logic [lsc_pkg::BLOCK_KEY_W-1:0] map_key  [NUM_SLOTS];
    bit                              map_live [NUM_SLOTS];
    logic [lsc_pkg::SLOT_ID_W-1:0]   map_age  [NUM_SLOTS];
    logic [lsc_pkg::CFG_W-1:0]       map_slots;
    logic [lsc_pkg::CFG_W-1:0]       map_free;

    lru_slot_cache uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // drop every entry and free all managed slots
    function automatic void clear_map();
        for (int i = 0; i < NUM_SLOTS; i++) begin
            map_key[i]  = '0;
            map_live[i] = 1'b0;
            map_age[i]  = '0;
        end
        map_free = map_slots;
    endfunction

    // register write: out-of-range values are clamped, and a write always clears
    function automatic void set_slots(logic [lsc_pkg::CFG_W-1:0] value);
        if (value == 0) begin
            map_slots = 7'd1;
        end else if (value > NUM_SLOTS) begin
            map_slots = NUM_SLOTS[lsc_pkg::CFG_W-1:0];
        end else begin
            map_slots = value;
        end
        clear_map();
    endfunction

    // make slot s the youngest; other live entries younger than limit (or all of them when all is set) age by one
    function automatic void promote(int s, bit all, logic [lsc_pkg::SLOT_ID_W-1:0] limit);
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (i != s && map_live[i] && (all || map_age[i] < limit)) begin
                map_age[i] = map_age[i] + 1'b1;
            end
        end
        map_age[s] = '0;
    endfunction

    // hit, hand out a free slot, or evict the oldest entry
    function automatic t_grant lookup_and_place(logic [lsc_pkg::BLOCK_KEY_W-1:0] key);
        t_grant g;
        int     s;
        bit     found;
        g = '0;
        s = -1;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (s < 0 && map_live[i] && map_key[i] == key) begin
                s = i;
            end
        end
        if (s >= 0) begin
            g.hit = 1'b1;
            promote(s, 1'b0, map_age[s]);
        end else if (map_free > 0) begin
            map_free    = map_free - 1'b1;
            s           = int'(map_free);
            map_live[s] = 1'b1;
            map_key[s]  = key;
            promote(s, 1'b1, '0);
        end else begin
            found = 1'b0;
            s     = 0;
            // lowest slot wins a tie on age
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (map_live[i] && (!found || map_age[i] > map_age[s])) begin
                    found = 1'b1;
                    s     = i;
                end
            end
            if (found) begin
                g.evicted     = 1'b1;
                g.evicted_key = map_key[s];
            end else begin
                s           = 0;
                map_live[0] = 1'b1;
            end
            map_key[s] = key;
            promote(s, 1'b1, '0);
        end
        g.slot_id = s[lsc_pkg::SLOT_ID_W-1:0];
        return g;
    endfunction

    function automatic logic [lsc_pkg::BLOCK_KEY_W-1:0] rand_key();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[lsc_pkg::BLOCK_KEY_W-1:0];
    endfunction

    function automatic void add_key(logic [lsc_pkg::BLOCK_KEY_W-1:0] key);
        t_order o;
        o = '{kind: ORD_KEY, key: key, cfg: '0, send_idle: 0, recv_idle: 0};
        order_q.push_back(o);
    endfunction

    function automatic void add_cfg(logic [lsc_pkg::CFG_W-1:0] value);
        t_order o;
        o = '{kind: ORD_CFG, key: '0, cfg: value, send_idle: 0, recv_idle: 0};
        order_q.push_back(o);
    endfunction

    function automatic void add_drain();
        t_order o;
        o = '{kind: ORD_DRAIN, key: '0, cfg: '0, send_idle: 0, recv_idle: 0};
        order_q.push_back(o);
    endfunction

    function automatic void add_mode(int send_idle, int recv_idle);
        t_order o;
        o = '{kind: ORD_MODE, key: '0, cfg: '0, send_idle: send_idle, recv_idle: recv_idle};
        order_q.push_back(o);
    endfunction

    // one setting: a key pool a little larger than the slot count, so hits and evictions mix
    function automatic void plan_phase(logic [lsc_pkg::CFG_W-1:0] cfg_value, int n_items);
        logic [lsc_pkg::BLOCK_KEY_W-1:0] pool [$];
        logic [lsc_pkg::BLOCK_KEY_W-1:0] k;
        int                              eff;
        int                              pool_size;
        eff = (cfg_value == 0) ? 1 : (cfg_value > NUM_SLOTS) ? NUM_SLOTS : int'(cfg_value);
        pool_size = eff + $urandom_range(1, 6);
        for (int i = 0; i < pool_size; i++) begin
            // some keys differ from an earlier one in a single bit
            if (i > 0 && $urandom_range(3) == 0) begin
                k = pool[$urandom_range(i - 1)];
                k = k ^ (48'd1 << $urandom_range(lsc_pkg::BLOCK_KEY_W - 1));
            end else begin
                k = rand_key();
            end
            pool.push_back(k);
        end
        add_cfg(cfg_value);
        for (int j = 0; j < n_items; j++) begin
            if (j == n_items / 2) begin
                add_drain();
            end
            if ($urandom_range(99) < 85) begin
                add_key(pool[$urandom_range(pool_size - 1)]);
            end else begin
                add_key(rand_key());
            end
        end
    endfunction

    function automatic void plan_directed();
        // extremes of the key at the reset slot count, then hits on them
        add_key('0);
        add_key('1);
        add_key(48'hAAAA_AAAA_AAAA);
        add_key(48'h5555_5555_5555);
        add_key('0);
        add_key('1);
        // zero is taken as one slot: every new key evicts the previous one
        add_cfg(7'd0);
        add_key(48'h1234_5678_9ABC);
        add_key(48'h1234_5678_9ABC);
        add_key(48'hFEDC_BA98_7654);
        add_key(48'h1234_5678_9ABC);
        // two slots: a hit saves its entry from eviction
        add_cfg(7'd2);
        add_key(48'h0000_0000_0011);
        add_key(48'h0000_0000_0022);
        add_key(48'h0000_0000_0011);
        add_key(48'h0000_0000_0033);
        add_key(48'h0000_0000_0022);
        // same value again still clears
        add_cfg(7'd2);
        add_key(48'h0000_0000_0033);
        // above the slot limit is clamped
        add_cfg(7'h7F);
        add_key(48'h0000_0000_0011);
    endfunction

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // item driver, changes on the falling edge
    always @(negedge i_clk) begin
        logic                          nxt_valid;
        logic [lsc_pkg::S_TDATA_W-1:0] nxt_data;
        logic                          nxt_we;
        logic [lsc_pkg::CFG_W-1:0]     nxt_wdata;
        t_order                        head;
        nxt_valid = s_axis_tvalid;
        nxt_data  = s_axis_tdata;
        nxt_we    = 1'b0;
        nxt_wdata = i_cfg_wdata;
        if (i_rst_n) begin
            if (slot_grants.size() == 0 && !s_axis_tvalid) begin
                quiet_count++;
            end else begin
                quiet_count = 0;
            end
            if (!s_axis_tvalid || key_taken) begin
                nxt_valid = 1'b0;
                if (order_q.size() > 0) begin
                    head = order_q[0];
                    case (head.kind)
                        ORD_KEY: begin
                            if ($urandom_range(99) >= send_idle_pct) begin
                                nxt_valid = 1'b1;
                                nxt_data  = head.key;
                                void'(order_q.pop_front());
                            end
                        end
                        ORD_CFG: begin
                            // only once the block has gone quiet
                            if (quiet_count >= QUIET_CYCLES) begin
                                nxt_we    = 1'b1;
                                nxt_wdata = head.cfg;
                                void'(order_q.pop_front());
                            end
                        end
                        ORD_DRAIN: begin
                            if (quiet_count >= QUIET_CYCLES) begin
                                void'(order_q.pop_front());
                            end
                        end
                        default: begin
                            send_idle_pct = head.send_idle;
                            recv_idle_pct = head.recv_idle;
                            void'(order_q.pop_front());
                        end
                    endcase
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
        s_axis_tvalid <= nxt_valid;
        s_axis_tdata  <= nxt_data;
        i_cfg_we      <= nxt_we;
        i_cfg_wdata   <= nxt_wdata;
    end

    // monitor: check results, predict accepted items, follow register writes
    always @(posedge i_clk) begin
        t_grant got;
        t_grant want;
        key_taken = 1'b0;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.slot_id     = m_axis_tdata[lsc_pkg::SLOT_ID_W-1:0];
                got.evicted_key = m_axis_tdata[lsc_pkg::SLOT_ID_W +: lsc_pkg::BLOCK_KEY_W];
                got.hit         = m_axis_tuser[lsc_pkg::TUSER_HIT];
                got.evicted     = m_axis_tuser[lsc_pkg::TUSER_EVICTED];
                if (slot_grants.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("%0t: unexpected item slot %0d hit %b evicted %b key %h",
                                 $realtime, got.slot_id, got.hit, got.evicted,
                                 got.evicted_key);
                    end
                end else begin
                    want = slot_grants.pop_front();
                    if (got.slot_id !== want.slot_id || got.hit !== want.hit ||
                        got.evicted !== want.evicted ||
                        got.evicted_key !== want.evicted_key) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS) begin
                            $display("%0t: mismatch exp slot %0d hit %b evicted %b key %h",
                                     $realtime, want.slot_id, want.hit, want.evicted,
                                     want.evicted_key);
                            $display("%0t:          got slot %0d hit %b evicted %b key %h",
                                     $realtime, got.slot_id, got.hit, got.evicted,
                                     got.evicted_key);
                        end
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                slot_grants.push_back(lookup_and_place(s_axis_tdata));
                key_taken = 1'b1;
            end
            if (i_cfg_we) begin
                set_slots(i_cfg_wdata);
            end
        end
    end

    // run limit
    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        map_slots = NUM_SLOTS[lsc_pkg::CFG_W-1:0];
        clear_map();

        // sender idles often, receiver stalls most of the time
        add_mode(37, 86);
        plan_directed();
        plan_phase(7'd64, 110);
        plan_phase(7'd1, 60);
        plan_phase(7'd7, 90);
        plan_phase(7'h7F, 110);
        // roles swapped
        add_mode(86, 37);
        plan_phase(7'd2, 70);
        plan_phase(7'd16, 110);
        plan_phase(7'd0, 50);
        plan_phase(7'd33, 100);
        plan_phase(7'd63, 100);
        // full rate both ways
        add_mode(0, 0);
        plan_phase(7'd5, 80);
        plan_phase(7'd64, 90);
        plan_phase(7'd100, 100);
        plan_phase(7'd3, 70);

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (order_q.size() > 0 || s_axis_tvalid || slot_grants.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);

        if (fail_count == 0 && slot_grants.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/lsc_pkg.sv
rtl/lsc_cell.sv
rtl/lru_slot_cache.sv
bench/lru_slot_cache_test.sv
